// File: hdl/assert_macros.svh
// Assertion helpers, included by oaat_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/oaat_pkg.sv
package oaat_pkg;

   localparam int BYTE_W      = 8;
   localparam int HASH_W      = 32;
   localparam int BUCKET_W    = 16;
   localparam int COUNT_W     = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;

   localparam logic [COUNT_W-1:0] BUCKET_COUNT_RESET = COUNT_W'(16);
   localparam logic [COUNT_W-1:0] MAX_BUCKETS        = COUNT_W'(65536);

   // Mixed (not yet finalized) hash of a completed key.
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } hash_entry_type;

endpackage

// File: hdl/oaat_front.sv
module oaat_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [oaat_pkg::BYTE_W-1:0]   req_tdata,
   input  logic                          req_tlast,
   input  logic                          queue_full,
   output oaat_pkg::hash_entry_type      push
);

   logic [oaat_pkg::HASH_W-1:0] run_hash_ff;
   logic [oaat_pkg::HASH_W-1:0] run_hash_in;
   logic [oaat_pkg::HASH_W-1:0] mixed;
   logic [oaat_pkg::HASH_W-1:0] sum_byte;
   logic [oaat_pkg::HASH_W-1:0] sum_shift;
   logic                        accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      sum_byte  = run_hash_ff + oaat_pkg::HASH_W'(req_tdata);
      sum_shift = sum_byte + (sum_byte << 10);
      mixed     = sum_shift ^ (sum_shift >> 6);
   end

   always_comb begin
      run_hash_in = run_hash_ff;
      push.valid  = 1'b0;
      push.hash   = mixed;
      if (accept) begin
         if (req_tlast) begin
            // The key is complete: hand it to the back end and start afresh.
            push.valid  = 1'b1;
            run_hash_in = '0;
         end else begin
            run_hash_in = mixed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_hash_ff <= '0;
      end else begin
         run_hash_ff <= run_hash_in;
      end
   end

endmodule

// File: hdl/oaat_queue.sv
module oaat_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  oaat_pkg::hash_entry_type push,
   input  logic                     pop,
   output oaat_pkg::hash_entry_type head,
   output logic                     full
);

   logic [oaat_pkg::HASH_W-1:0]   store_ff [oaat_pkg::QUEUE_DEPTH];
   logic [oaat_pkg::QUEUE_AW-1:0] wr_ptr_ff;
   logic [oaat_pkg::QUEUE_AW-1:0] wr_ptr_in;
   logic [oaat_pkg::QUEUE_AW-1:0] rd_ptr_ff;
   logic [oaat_pkg::QUEUE_AW-1:0] rd_ptr_in;
   logic [oaat_pkg::QUEUE_CW-1:0] count_ff;
   logic [oaat_pkg::QUEUE_CW-1:0] count_in;
   logic                          do_push;
   logic                          do_pop;

   assign full       = (count_ff == oaat_pkg::QUEUE_CW'(oaat_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.hash  = store_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/oaat_back.sv
`include "assert_macros.svh"

module oaat_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [oaat_pkg::COUNT_W-1:0]  bucket_count,
   input  oaat_pkg::hash_entry_type      head,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [oaat_pkg::HASH_W-1:0]   rsp_hash,
   output logic [oaat_pkg::BUCKET_W-1:0] rsp_bucket
);

   localparam int STATE_W = 3;
   localparam int STEP_W  = $clog2(oaat_pkg::HASH_W);

   localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] ST_FIN1 = 3'd1;
   localparam logic [STATE_W-1:0] ST_FIN2 = 3'd2;
   localparam logic [STATE_W-1:0] ST_FIN3 = 3'd3;
   localparam logic [STATE_W-1:0] ST_DIV  = 3'd4;
   localparam logic [STATE_W-1:0] ST_DONE = 3'd5;

   logic [STATE_W-1:0]            state_ff,      state_in;
   logic [oaat_pkg::HASH_W-1:0]   hash_ff,       hash_in;
   logic [oaat_pkg::HASH_W-1:0]   quo_ff,        quo_in;
   logic [oaat_pkg::COUNT_W-1:0]  rem_ff,        rem_in;
   logic [oaat_pkg::COUNT_W-1:0]  div_ff,        div_in;
   logic [STEP_W-1:0]             step_ff,       step_in;
   logic                          rsp_valid_ff,  rsp_valid_in;
   logic [oaat_pkg::HASH_W-1:0]   rsp_hash_ff,   rsp_hash_in;
   logic [oaat_pkg::BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic [oaat_pkg::HASH_W-1:0]   fin_hash;
   logic [oaat_pkg::COUNT_W:0]    trial;
   logic [oaat_pkg::COUNT_W-1:0]  eff_count;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_hash   = rsp_hash_ff;
   assign rsp_bucket = rsp_bucket_ff;

   // A count of zero acts as one, and counts beyond the table size saturate.
   always_comb begin
      eff_count = bucket_count;
      if (bucket_count == '0) begin
         eff_count = oaat_pkg::COUNT_W'(1);
      end else if (bucket_count > oaat_pkg::MAX_BUCKETS) begin
         eff_count = oaat_pkg::MAX_BUCKETS;
      end
   end

   assign fin_hash = hash_ff + (hash_ff << 15);
   assign trial    = {rem_ff, quo_ff[oaat_pkg::HASH_W-1]};

   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_bucket_in = rsp_bucket_ff;
      pop           = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               hash_in  = head.hash;
               state_in = ST_FIN1;
            end
         end
         ST_FIN1: begin
            hash_in  = hash_ff + (hash_ff << 3);
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            hash_in  = hash_ff ^ (hash_ff >> 11);
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            hash_in  = fin_hash;
            quo_in   = fin_hash;
            rem_in   = '0;
            div_in   = eff_count;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division, one dividend bit per cycle; only the
            // remainder is kept.
            if (trial >= {1'b0, div_ff}) begin
               rem_in = oaat_pkg::COUNT_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = trial[oaat_pkg::COUNT_W-1:0];
            end
            quo_in  = quo_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(oaat_pkg::HASH_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_hash_in   = hash_ff;
               rsp_bucket_in = rem_ff[oaat_pkg::BUCKET_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hash_ff       <= hash_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_CLK_RST(a_rem_below_div, clock, reset, (state_ff == ST_DIV) |-> (rem_ff < div_ff), "remainder reached the divisor")
   `ASSERT_CLK_RST(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE), "result raised outside the done state")
   `ASSERT_CLK_RST(a_done_delivers, clock, reset, ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready)) |=> (rsp_valid_ff && (state_ff == ST_IDLE)), "finished result was not loaded")

endmodule

// File: hdl/one_at_a_time_hash_bucket_unit.sv
// One-at-a-time hash with bucket index.
// Key bytes are taken one per cycle while the four-entry key queue has room.
// After its last byte a key is popped, passes the finalize states FIN1 to
// FIN3 and a bit-serial remainder over all 32 hash bits, and is loaded once
// any held result is taken; the next key is popped only after that load.
// Synchronous reset clears the running hash, queue and result valid, and
// sets the bucket count to 16.
module one_at_a_time_hash_bucket_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] key_byte
   input  logic                          req_tlast,   // last_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,   // [31:0] hash_value, [47:32] bucket_index
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [oaat_pkg::COUNT_W-1:0]  csr_data     // bucket_count
);

   logic [oaat_pkg::COUNT_W-1:0]  bucket_count_ff;
   logic [oaat_pkg::COUNT_W-1:0]  bucket_count_in;
   oaat_pkg::hash_entry_type      push;
   oaat_pkg::hash_entry_type      head;
   logic                          queue_full;
   logic                          pop;
   logic [oaat_pkg::HASH_W-1:0]   rsp_hash;
   logic [oaat_pkg::BUCKET_W-1:0] rsp_bucket;

   assign csr_ready       = 1'b1;
   assign bucket_count_in = (csr_valid && csr_ready) ? csr_data : bucket_count_ff;
   assign rsp_tdata       = {rsp_bucket, rsp_hash};

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= oaat_pkg::BUCKET_COUNT_RESET;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   oaat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push)
   );

   oaat_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   oaat_back u_back (
      .clock        (clock),
      .reset        (reset),
      .bucket_count (bucket_count_ff),
      .head         (head),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_hash     (rsp_hash),
      .rsp_bucket   (rsp_bucket)
   );

endmodule

// File: bench/tb_one_at_a_time_hash_bucket_unit.sv
`timescale 1ns / 1ps

module tb_one_at_a_time_hash_bucket_unit;

   localparam int DRAIN_CYCLES    = 45;
   localparam int HOLD_CYCLES     = 400;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int NUM_PHASES      = 6;
   localparam int NUM_ROWS        = 23;

   typedef enum logic {ROW_KEY, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [oaat_pkg::HASH_W-1:0]   hash;
      logic [oaat_pkg::BUCKET_W-1:0] bucket;
   } digest_type;

   // For key rows the byte sits in the low bits of value.
   typedef struct packed {
      row_kind_type                  kind;
      logic [oaat_pkg::COUNT_W-1:0]  value;
      logic                          last;
      logic                          typed;
      logic [oaat_pkg::HASH_W-1:0]   t_hash;
      logic [oaat_pkg::BUCKET_W-1:0] t_bucket;
   } dir_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata = '0;   // [7:0] key_byte
   logic                          req_tlast = 1'b0; // last_byte
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [47:0]                   rsp_tdata;        // [31:0] hash_value, [47:32] bucket_index
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [oaat_pkg::COUNT_W-1:0]  csr_data = '0;    // bucket_count

   // Predictor state.
   logic [oaat_pkg::HASH_W-1:0]   running_hash_q;
   logic [oaat_pkg::COUNT_W-1:0]  bucket_count_q;
   digest_type                    pending_digests[$];

   int mismatch_count = 0;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int hold_req       = 0;
   int hold_ack       = 0;
   int hold_left      = 0;

   dir_row_type dir_table [NUM_ROWS] = '{
      '{ROW_KEY, 17'h000_00, 1'b1, 1'b1, 32'h0000_0000, 16'h0000},
      '{ROW_KEY, 17'h000_FF, 1'b1, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_12, 1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_34, 1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_AB, 1'b1, 1'b0, '0, '0},
      '{ROW_CSR, 17'd1,      1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_A5, 1'b1, 1'b0, '0, '0},
      '{ROW_CSR, 17'd0,      1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_5A, 1'b1, 1'b0, '0, '0},
      '{ROW_CSR, 17'd65536,  1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_FF, 1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_00, 1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_80, 1'b1, 1'b0, '0, '0},
      '{ROW_CSR, 17'h1_FFFF, 1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_7F, 1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_01, 1'b1, 1'b0, '0, '0},
      '{ROW_CSR, 17'd65537,  1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_C3, 1'b1, 1'b0, '0, '0},
      '{ROW_CSR, 17'd1000,   1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_00, 1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_00, 1'b0, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_00, 1'b1, 1'b0, '0, '0},
      '{ROW_KEY, 17'h000_55, 1'b1, 1'b0, '0, '0}
   };

   one_at_a_time_hash_bucket_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [oaat_pkg::HASH_W-1:0] stir_byte(
         logic [oaat_pkg::HASH_W-1:0] h, logic [7:0] b);
      logic [oaat_pkg::HASH_W-1:0] x;
      x = h + oaat_pkg::HASH_W'(b);
      x = x + (x << 10);
      x = x ^ (x >> 6);
      return x;
   endfunction

   function automatic logic [oaat_pkg::HASH_W-1:0] avalanche(
         logic [oaat_pkg::HASH_W-1:0] h);
      logic [oaat_pkg::HASH_W-1:0] x;
      x = h + (h << 3);
      x = x ^ (x >> 11);
      x = x + (x << 15);
      return x;
   endfunction

   // A zero count behaves as one bucket; counts past the maximum saturate.
   function automatic logic [oaat_pkg::BUCKET_W-1:0] bucket_of(
         logic [oaat_pkg::HASH_W-1:0] h, logic [oaat_pkg::COUNT_W-1:0] cnt);
      logic [oaat_pkg::HASH_W-1:0] n;
      n = oaat_pkg::HASH_W'(cnt);
      if (n == 0) begin
         n = 1;
      end
      if (n > oaat_pkg::HASH_W'(oaat_pkg::MAX_BUCKETS)) begin
         n = oaat_pkg::HASH_W'(oaat_pkg::MAX_BUCKETS);
      end
      return oaat_pkg::BUCKET_W'(h % n);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic typed, input digest_type typed_digest);
      digest_type d;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      running_hash_q = stir_byte(running_hash_q, b);
      if (last) begin
         d.hash   = avalanche(running_hash_q);
         d.bucket = bucket_of(d.hash, bucket_count_q);
         running_hash_q = '0;
         pending_digests.push_back(typed ? typed_digest : d);
      end
   endtask

   // Lets every outstanding key finish before anything else happens.
   task automatic drain_keys();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_digests.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_bucket_count(input logic [oaat_pkg::COUNT_W-1:0] cnt);
      drain_keys();
      csr_data  <= cnt;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      bucket_count_q = cnt;
      csr_valid <= 1'b0;
   endtask

   // Result side: check each transaction, then pick the next ready value.
   always @(posedge clock) begin : rsp_side
      digest_type got;
      digest_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hash   = rsp_tdata[31:0];
            got.bucket = rsp_tdata[47:32];
            if (pending_digests.size() == 0) begin
               $error("unexpected result: hash_value %h bucket_index %h",
                      got.hash, got.bucket);
               mismatch_count++;
            end else begin
               want = pending_digests.pop_front();
               if (got.hash !== want.hash) begin
                  $error("hash_value: expected %h, got %h", want.hash, got.hash);
                  mismatch_count++;
               end
               if (got.bucket !== want.bucket) begin
                  $error("bucket_index: expected %h, got %h", want.bucket, got.bucket);
                  mismatch_count++;
               end
            end
         end
         if (hold_ack != hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_ack  = hold_req;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      #6_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int items;
      int len;
      bit paused;
      logic [oaat_pkg::COUNT_W-1:0] phase_counts [NUM_PHASES];

      running_hash_q = '0;
      bucket_count_q = oaat_pkg::BUCKET_COUNT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed rows.
      req_idle_pct = 36;
      rsp_idle_pct = 64;
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CSR) begin
            write_bucket_count(dir_table[i].value);
         end else begin
            send_byte(dir_table[i].value[7:0], dir_table[i].last, dir_table[i].typed,
                      digest_type'{dir_table[i].t_hash, dir_table[i].t_bucket});
         end
      end

      // Random keys, one bucket count per phase, extremes included.
      phase_counts[0] = 17'd65536;
      phase_counts[1] = 17'd1;
      phase_counts[2] = 17'h1_FFFF;
      phase_counts[3] = oaat_pkg::COUNT_W'($urandom_range(2, 65535));
      phase_counts[4] = 17'd0;
      phase_counts[5] = oaat_pkg::COUNT_W'($urandom_range(0, 131071));
      paused = 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_bucket_count(phase_counts[ph]);
         case (ph / 2)
            0: begin
               req_idle_pct = 36;
               rsp_idle_pct = 64;
            end
            1: begin
               req_idle_pct = 64;
               rsp_idle_pct = 36;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         items = 0;
         // Stall the result side for a long stretch while short keys keep
         // coming, so the key queue fills and input backpressure shows up.
         if (ph == 1) begin
            hold_req++;
            repeat (24) begin
               send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
               items++;
            end
         end
         while (items < ITEMS_PER_PHASE) begin
            if (ph == 3 && !paused && items >= ITEMS_PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               do @(posedge clock); while (pending_digests.size() != 0);
               paused = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               send_byte(8'($urandom_range(0, 255)), k == len - 1, 1'b0, '0);
               items++;
            end
         end
      end

      drain_keys();
      if (pending_digests.size() != 0) begin
         $error("%0d results never arrived", pending_digests.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/oaat_pkg.sv
hdl/oaat_front.sv
hdl/oaat_queue.sv
hdl/oaat_back.sv
hdl/one_at_a_time_hash_bucket_unit.sv
bench/tb_one_at_a_time_hash_bucket_unit.sv
